// ===== rtl/pfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, codes and small helper functions of the Playfair cipher core.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int GRID_SIDE   = 5;
    localparam int CELLS       = GRID_SIDE * GRID_SIDE;
    localparam int LETTERS     = 26;
    localparam int LETTER_W    = 5;
    localparam int PLACE_W     = 5;
    localparam int COORD_W     = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
    localparam logic [LETTER_W-1:0] LETTER_X = 5'd23;

    // Division by the grid side through a reciprocal: (p * 13) >> 6 is exact
    // for every cell index of the square.
    localparam int DIV_MUL   = 13;
    localparam int DIV_SHIFT = 6;

    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_KEY   = 3'd1,
        OP_CLOSE = 3'd2,
        OP_TEXT  = 3'd3,
        OP_END   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_KEY,
        CMD_CLOSE,
        CMD_PAIR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [LETTER_W-1:0]   first;
        logic [LETTER_W-1:0]   second;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CLOSE,
        BK_PLACE,
        BK_EMIT0,
        BK_EMIT1
    } back_state_t;

    function automatic logic [COORD_W-1:0] row_of(input logic [PLACE_W-1:0] p);
        logic [9:0] prod;
        prod = 10'(p) * 10'(DIV_MUL);
        return prod[DIV_SHIFT +: COORD_W];
    endfunction

    function automatic logic [COORD_W-1:0] col_of(input logic [PLACE_W-1:0] p);
        logic [PLACE_W-1:0] base;
        base = PLACE_W'(row_of(p)) * PLACE_W'(GRID_SIDE);
        return COORD_W'(p - base);
    endfunction

    function automatic logic [COORD_W-1:0] wrap_inc(input logic [COORD_W-1:0] v);
        return (v == COORD_W'(GRID_SIDE - 1)) ? '0 : COORD_W'(v + 1'b1);
    endfunction

    function automatic logic [PLACE_W-1:0] cell_index(input logic [COORD_W-1:0] r,
                                                      input logic [COORD_W-1:0] c);
        return PLACE_W'(PLACE_W'(r) * PLACE_W'(GRID_SIDE) + PLACE_W'(c));
    endfunction

endpackage

// ===== rtl/pfc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module pfc_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== rtl/pfc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_front
// Input side: folds J into I, pairs text letters and issues commands.
// ----------------------------------------------------------------------------
module pfc_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [2:0]              s_operation,
    input  logic [4:0]              s_letter,
    input  logic                    q_full,
    output logic                    q_push,
    output pfc_pkg::cmd_t           q_cmd
);
    import pfc_pkg::*;

    logic                held_valid_reg;
    logic                held_valid_next;
    logic [LETTER_W-1:0] held_letter_reg;
    logic [LETTER_W-1:0] held_letter_next;
    logic [LETTER_W-1:0] folded;
    logic                in_range;
    logic                accept;
    logic                cmd_valid;

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign folded   = (s_letter == LETTER_J) ? LETTER_I : s_letter;
    assign in_range = (s_letter < LETTER_W'(LETTERS));

    always_comb begin
        cmd_valid        = 1'b0;
        q_cmd.kind       = CMD_START;
        q_cmd.first      = folded;
        q_cmd.second     = LETTER_X;
        held_valid_next  = held_valid_reg;
        held_letter_next = held_letter_reg;
        unique case (op_t'(s_operation))
            OP_START: begin
                cmd_valid  = 1'b1;
                q_cmd.kind = CMD_START;
            end
            OP_KEY: begin
                cmd_valid  = in_range;
                q_cmd.kind = CMD_KEY;
            end
            OP_CLOSE: begin
                cmd_valid  = 1'b1;
                q_cmd.kind = CMD_CLOSE;
            end
            OP_TEXT: begin
                q_cmd.kind = CMD_PAIR;
                if (in_range) begin
                    if (!held_valid_reg) begin
                        held_valid_next  = 1'b1;
                        held_letter_next = folded;
                    end else if (held_letter_reg == folded) begin
                        // A doubled letter is split by X and stays held.
                        cmd_valid = 1'b1;
                    end else begin
                        cmd_valid       = 1'b1;
                        q_cmd.first     = held_letter_reg;
                        q_cmd.second    = folded;
                        held_valid_next = 1'b0;
                    end
                end
            end
            OP_END: begin
                q_cmd.kind  = CMD_PAIR;
                q_cmd.first = held_letter_reg;
                if (held_valid_reg) begin
                    cmd_valid       = 1'b1;
                    held_valid_next = 1'b0;
                end
            end
            default: begin
                cmd_valid = 1'b0;
            end
        endcase
    end

    assign q_push = accept && cmd_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg  <= 1'b0;
            held_letter_reg <= '0;
        end else if (accept) begin
            held_valid_reg  <= held_valid_next;
            held_letter_reg <= held_letter_next;
        end
    end

endmodule

// ===== rtl/pfc_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_fifo
// Short command queue between the input side and the execution side.
// ----------------------------------------------------------------------------
module pfc_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  pfc_pkg::cmd_t  push_cmd,
    output logic           full,
    input  logic           pop,
    output pfc_pkg::cmd_t  pop_cmd,
    output logic           empty
);
    import pfc_pkg::*;

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t               entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    assign full    = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop) begin
            count_next = COUNT_W'(count_reg + 1'b1);
        end else if (pop && !push) begin
            count_next = COUNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/pfc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_back
// Execution side: builds the key square and encrypts letter pairs.
// ----------------------------------------------------------------------------
module pfc_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_empty,
    input  pfc_pkg::cmd_t  q_cmd,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [4:0]     m_cipher_letter,
    output logic           m_last_of_pair
);
    import pfc_pkg::*;

    back_state_t         state_reg;
    back_state_t         state_next;
    logic [PLACE_W-1:0]  fill_reg;
    logic [PLACE_W-1:0]  fill_next;
    logic [LETTERS-1:0]  used_reg;
    logic [LETTERS-1:0]  used_next;
    logic [LETTER_W-1:0] k_reg;
    logic [LETTER_W-1:0] k_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    logic [LETTER_W-1:0] m_cipher_reg;
    logic [LETTER_W-1:0] m_cipher_next;
    logic                m_last_reg;
    logic                m_last_next;

    logic                slot_free;
    logic                place_en;
    logic [LETTER_W-1:0] place_letter;
    logic                do_place;
    logic                clear_key;
    logic                lp_re;
    logic                ks_re;
    logic                out_load;
    logic                out_second;

    logic [PLACE_W-1:0]  lp_rdata_a;
    logic [PLACE_W-1:0]  lp_rdata_b;
    logic [LETTER_W-1:0] ks_rdata_a;
    logic [LETTER_W-1:0] ks_rdata_b;
    logic [PLACE_W-1:0]  ks_raddr_a;
    logic [PLACE_W-1:0]  ks_raddr_b;
    logic [COORD_W-1:0]  ra, ca, rb, cb;

    assign slot_free = !m_valid_reg || m_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    unique case (q_cmd.kind)
                        CMD_CLOSE: state_next = BK_CLOSE;
                        CMD_PAIR:  state_next = BK_PLACE;
                        default:   state_next = BK_IDLE;
                    endcase
                end
            end
            BK_CLOSE: begin
                if (k_reg == LETTER_W'(LETTERS - 1)) begin
                    state_next = BK_IDLE;
                end
            end
            BK_PLACE: state_next = BK_EMIT0;
            BK_EMIT0: begin
                if (slot_free) begin
                    state_next = BK_EMIT1;
                end
            end
            BK_EMIT1: begin
                if (slot_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        q_pop        = 1'b0;
        place_en     = 1'b0;
        place_letter = q_cmd.first;
        clear_key    = 1'b0;
        lp_re        = 1'b0;
        ks_re        = 1'b0;
        out_load     = 1'b0;
        out_second   = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                q_pop = !q_empty;
                if (!q_empty) begin
                    unique case (q_cmd.kind)
                        CMD_START: clear_key = 1'b1;
                        CMD_KEY:   place_en  = 1'b1;
                        CMD_PAIR:  lp_re     = 1'b1;
                        default:   place_en  = 1'b0;
                    endcase
                end
            end
            BK_CLOSE: begin
                place_letter = k_reg;
                place_en     = (k_reg != LETTER_J);
            end
            BK_PLACE: ks_re = 1'b1;
            BK_EMIT0: out_load = slot_free;
            BK_EMIT1: begin
                out_load   = slot_free;
                out_second = 1'b1;
            end
            default: q_pop = 1'b0;
        endcase
    end

    assign do_place = place_en && !used_reg[place_letter] && (fill_reg < PLACE_W'(CELLS));

    // Digraph rules, from the two places read out of the letter table.
    always_comb begin
        ra = row_of(lp_rdata_a);
        ca = col_of(lp_rdata_a);
        rb = row_of(lp_rdata_b);
        cb = col_of(lp_rdata_b);
        if (ra == rb) begin
            ks_raddr_a = cell_index(ra, wrap_inc(ca));
            ks_raddr_b = cell_index(rb, wrap_inc(cb));
        end else if (ca == cb) begin
            ks_raddr_a = cell_index(wrap_inc(ra), ca);
            ks_raddr_b = cell_index(wrap_inc(rb), cb);
        end else begin
            ks_raddr_a = cell_index(ra, cb);
            ks_raddr_b = cell_index(rb, ca);
        end
    end

    pfc_ram #(
        .WIDTH (LETTER_W),
        .DEPTH (CELLS)
    ) u_key_square (
        .aclk    (aclk),
        .we      (do_place),
        .waddr   (fill_reg),
        .wdata   (place_letter),
        .re      (ks_re),
        .raddr_a (ks_raddr_a),
        .raddr_b (ks_raddr_b),
        .rdata_a (ks_rdata_a),
        .rdata_b (ks_rdata_b)
    );

    pfc_ram #(
        .WIDTH (PLACE_W),
        .DEPTH (LETTERS)
    ) u_letter_place (
        .aclk    (aclk),
        .we      (do_place),
        .waddr   (place_letter),
        .wdata   (fill_reg),
        .re      (lp_re),
        .raddr_a (q_cmd.first),
        .raddr_b (q_cmd.second),
        .rdata_a (lp_rdata_a),
        .rdata_b (lp_rdata_b)
    );

    always_comb begin
        fill_next = fill_reg;
        used_next = used_reg;
        if (clear_key) begin
            fill_next = '0;
            used_next = '0;
        end else if (do_place) begin
            fill_next               = PLACE_W'(fill_reg + 1'b1);
            used_next[place_letter] = 1'b1;
        end
        k_next = (state_reg == BK_CLOSE) ? LETTER_W'(k_reg + 1'b1) : '0;

        m_valid_next  = m_valid_reg && !m_ready;
        m_cipher_next = m_cipher_reg;
        m_last_next   = m_last_reg;
        if (out_load) begin
            m_valid_next  = 1'b1;
            m_cipher_next = out_second ? ks_rdata_b : ks_rdata_a;
            m_last_next   = out_second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            fill_reg    <= '0;
            used_reg    <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            used_reg    <= used_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_cipher_reg <= m_cipher_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_cipher_letter = m_cipher_reg;
    assign m_last_of_pair  = m_last_reg;

endmodule

// ===== rtl/playfair_digraph_cipher_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_core
// Playfair encryption of letters A=0..Z=25 with a loadable 5x5 key square.
// ----------------------------------------------------------------------------
// Usage: the s_ channel takes one operation per transfer (start key, key
// letter, close key, text letter, end of text) with its letter. The m_
// channel returns cipher letters, two per pair, m_last_of_pair set on the
// second. Input and output are parted by a two-entry command queue, so the
// input keeps taking items while a result waits on the output.
// Sequencing: a key letter or start is handled at dispatch in the execution
// side, a close key steps through the alphabet letters after dispatch, and a
// pair passes dispatch together with the letter-place read, the key-square
// read, then one output state per cipher letter. These steps are set by the
// two registered RAM reads of the execution sequencer. The queue entry, the
// letter-place read, the key-square read and the output register lie between
// the text transfer that completes a pair and its first cipher letter.
// Reset clears the queue, the held text letter, the fill count and the used
// letter flags; the key square must be loaded again before use. When the
// receiver holds m_ready low, the output register holds, the sequencer waits
// and the queue fills, after which s_ready drops.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_operation,
    input  logic [4:0] s_letter,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [4:0] m_cipher_letter,
    output logic       m_last_of_pair
);
    import pfc_pkg::*;

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    cmd_t push_cmd;
    cmd_t pop_cmd;

    pfc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_letter    (s_letter),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd)
    );

    pfc_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    pfc_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .q_cmd           (pop_cmd),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cipher_letter (m_cipher_letter),
        .m_last_of_pair  (m_last_of_pair)
    );

`ifndef SYNTHESIS
    a_queue_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_push && q_full))
        else $error("command queue written while full");

    a_queue_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("command queue read while empty");

    a_pair_second_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_of_pair) |=> (m_valid && m_last_of_pair))
        else $error("second letter of a pair did not follow the first");
`endif

endmodule
